[rtl/pointer_region_shape_lookup_macros.svh]
// assertion macros used by the pointer region lookup rtl
`ifndef POINTER_REGION_SHAPE_LOOKUP_MACROS_SVH
`define POINTER_REGION_SHAPE_LOOKUP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PRSL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PRSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/prsl_pkg.sv]
// shared widths, defaults and codes of the pointer region lookup
package prsl_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned CoordBitsDef  = 10;

  localparam int unsigned IndexW = 4;
  localparam int unsigned ImageW = 8;
  localparam int unsigned CountW = 5;

  localparam logic [CountW-1:0] CountRst = CountW'(1);

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

endpackage

[rtl/prsl_ifs.sv]
// handshake channels of the pointer region lookup: request, response, config

interface prsl_req_if #(
  parameter int unsigned CoordBits = prsl_pkg::CoordBitsDef
) ();
  import prsl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [IndexW-1:0]    entry_index;
  logic [CoordBits-1:0] region_left;
  logic [CoordBits-1:0] region_top;
  logic [CoordBits-1:0] region_right;
  logic [CoordBits-1:0] region_bottom;
  logic [ImageW-1:0]    region_image;
  logic [ImageW-1:0]    region_hotspot;
  logic [CoordBits-1:0] cursor_x;
  logic [CoordBits-1:0] cursor_y;

  modport source (
    output valid, op, entry_index, region_left, region_top, region_right,
           region_bottom, region_image, region_hotspot, cursor_x, cursor_y,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, region_left, region_top, region_right,
           region_bottom, region_image, region_hotspot, cursor_x, cursor_y,
    output ready
  );
endinterface

interface prsl_rsp_if ();
  import prsl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ImageW-1:0] image_number;
  logic [ImageW-1:0] hotspot_offset;
  logic [IndexW-1:0] matched_index;
  logic [ImageW-1:0] previous_image;

  modport source (
    output valid, image_number, hotspot_offset, matched_index, previous_image,
    input  ready
  );
  modport sink (
    input  valid, image_number, hotspot_offset, matched_index, previous_image,
    output ready
  );
endinterface

interface prsl_cfg_if ();
  import prsl_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink (input valid, entry_count, output ready);
endinterface

[rtl/prsl_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module prsl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pointer_region_shape_lookup.sv]
// pointer region lookup: write items fill the region ram, one per cycle back to back while idle
// a query scans entries 1..count-1 one per cycle through the ram read port,
// then entry 0 as default, and stops at the first hit; the ram read data is
// registered, the hit goes to a done state and then to the output register;
// no item is accepted until the result is loaded into the output register
// reset: entry_count 1, current image 0, no result pending; ram is not cleared
`include "pointer_region_shape_lookup_macros.svh"

module pointer_region_shape_lookup #(
  parameter int unsigned MaxEntries = prsl_pkg::MaxEntriesDef,
  parameter int unsigned CoordBits  = prsl_pkg::CoordBitsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  prsl_req_if.sink   req_i,
  prsl_rsp_if.source rsp_o,
  prsl_cfg_if.sink   cfg_i
);
  import prsl_pkg::*;

  localparam int unsigned IdxW     = $clog2(MaxEntries);
  localparam int unsigned CntW     = $clog2(MaxEntries + 1);
  localparam int unsigned EntryW   = 4 * CoordBits + 2 * ImageW;
  localparam int unsigned HotLsb   = 0;
  localparam int unsigned ImgLsb   = ImageW;
  localparam int unsigned BotLsb   = 2 * ImageW;
  localparam int unsigned RightLsb = BotLsb + CoordBits;
  localparam int unsigned TopLsb   = RightLsb + CoordBits;
  localparam int unsigned LeftLsb  = TopLsb + CoordBits;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CountW-1:0]    count_q;
  logic [CntW-1:0]      limit;
  logic [CntW-1:0]      iss_q, iss_d;
  logic                 last_q, last_d;
  logic                 chk_vld_q, chk_vld_d;
  logic                 chk_def_q, chk_def_d;
  logic [IdxW-1:0]      chk_idx_q, chk_idx_d;
  logic [CoordBits-1:0] x_q, y_q;
  logic [ImageW-1:0]    res_img_q, res_img_d;
  logic [ImageW-1:0]    res_hot_q, res_hot_d;
  logic [IdxW-1:0]      res_idx_q, res_idx_d;
  logic [ImageW-1:0]    cur_img_q, cur_img_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_load;
  logic [ImageW-1:0]    out_img_q, out_hot_q, out_prev_q;
  logic [IndexW-1:0]    out_idx_q;

  logic                 in_acc;
  logic                 ram_we, ram_re;
  logic [IdxW-1:0]      ram_waddr, ram_raddr;
  logic [EntryW-1:0]    ram_wdata, ram_rdata;
  logic [CoordBits-1:0] e_left, e_top, e_right, e_bottom;
  logic [ImageW-1:0]    e_img, e_hot;
  logic                 holds, hit, dflt_iss;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountRst;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.entry_count;
    end
  end

  // a count of zero acts as one, a large count is clamped to the table depth
  always_comb begin
    if (count_q == '0) begin
      limit = CntW'(1);
    end else if (32'(count_q) > MaxEntries) begin
      limit = CntW'(MaxEntries);
    end else begin
      limit = CntW'(count_q);
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign in_acc      = req_i.valid && req_i.ready;

  assign ram_we    = in_acc && (req_i.op == OpWrite) &&
                     (32'(req_i.entry_index) < MaxEntries);
  assign ram_waddr = IdxW'(req_i.entry_index);
  assign ram_wdata = {req_i.region_left, req_i.region_top, req_i.region_right,
                      req_i.region_bottom, req_i.region_image, req_i.region_hotspot};

  prsl_ram #(
    .Width (EntryW),
    .Depth (MaxEntries)
  ) u_region_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign e_left   = ram_rdata[LeftLsb +: CoordBits];
  assign e_top    = ram_rdata[TopLsb +: CoordBits];
  assign e_right  = ram_rdata[RightLsb +: CoordBits];
  assign e_bottom = ram_rdata[BotLsb +: CoordBits];
  assign e_img    = ram_rdata[ImgLsb +: ImageW];
  assign e_hot    = ram_rdata[HotLsb +: ImageW];

  assign holds = (x_q >= e_left) && (y_q >= e_top) && (e_right >= x_q) && (e_bottom >= y_q);
  // the default entry always wins once every other entry missed
  assign hit   = chk_vld_q && (chk_def_q || holds);

  assign dflt_iss  = (iss_q == limit);
  assign ram_re    = (state_q == StScan) && !last_q && !hit;
  assign ram_raddr = dflt_iss ? '0 : iss_q[IdxW-1:0];

  assign out_load = (state_q == StDone) && (!out_vld_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    last_d    = last_q;
    chk_vld_d = ram_re;
    chk_def_d = chk_def_q;
    chk_idx_d = chk_idx_q;
    res_img_d = res_img_q;
    res_hot_d = res_hot_q;
    res_idx_d = res_idx_q;
    cur_img_d = cur_img_q;
    out_vld_d = out_vld_q;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc && (req_i.op == OpQuery)) begin
          state_d = StScan;
          iss_d   = CntW'(1);
          last_d  = 1'b0;
        end
      end
      StScan: begin
        if (ram_re) begin
          iss_d     = iss_q + CntW'(1);
          last_d    = dflt_iss;
          chk_idx_d = ram_raddr;
          chk_def_d = dflt_iss;
        end
        if (hit) begin
          res_img_d = e_img;
          res_hot_d = e_hot;
          res_idx_d = chk_idx_q;
          state_d   = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          cur_img_d = res_img_q;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      iss_q     <= '0;
      last_q    <= 1'b0;
      chk_vld_q <= 1'b0;
      cur_img_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      last_q    <= last_d;
      chk_vld_q <= chk_vld_d;
      cur_img_q <= cur_img_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_def_q <= chk_def_d;
    chk_idx_q <= chk_idx_d;
    res_img_q <= res_img_d;
    res_hot_q <= res_hot_d;
    res_idx_q <= res_idx_d;
    if (in_acc) begin
      x_q <= req_i.cursor_x;
      y_q <= req_i.cursor_y;
    end
    if (out_load) begin
      out_img_q  <= res_img_q;
      out_hot_q  <= res_hot_q;
      out_idx_q  <= IndexW'(res_idx_q);
      out_prev_q <= cur_img_q;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.image_number   = out_img_q;
  assign rsp_o.hotspot_offset = out_hot_q;
  assign rsp_o.matched_index  = out_idx_q;
  assign rsp_o.previous_image = out_prev_q;

  `PRSL_ASSERT_IMPLY(a_write_idle, clk_i, rst_ni, ram_we, state_q == StIdle,
                     "region write outside idle")
  `PRSL_ASSERT_IMPLY(a_iss_range, clk_i, rst_ni, (state_q == StScan) && !last_q,
                     iss_q <= limit, "scan ran past entry limit")
  `PRSL_ASSERT_IMPLY(a_dflt_idx, clk_i, rst_ni, chk_vld_q && chk_def_q, chk_idx_q == '0,
                     "default read not at entry zero")
  `PRSL_ASSERT_NEXT(a_hit_done, clk_i, rst_ni, (state_q == StScan) && hit,
                    state_q == StDone, "hit did not end the scan")
  `PRSL_ASSERT_NEXT(a_load_out, clk_i, rst_ni, out_load, out_vld_q && (state_q == StIdle),
                    "result not presented after load")

endmodule

[sim/pointer_hit_checker.sv]
// watches the lookup channels, predicts each query's hit and compares the results
module pointer_hit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  prsl_req_if         req_mon,
  prsl_rsp_if         rsp_mon,
  prsl_cfg_if         cfg_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import prsl_pkg::*;

  localparam int unsigned CW = CoordBitsDef;

  typedef struct packed {
    logic [CW-1:0]     left;
    logic [CW-1:0]     top;
    logic [CW-1:0]     right;
    logic [CW-1:0]     bottom;
    logic [ImageW-1:0] image;
    logic [ImageW-1:0] hotspot;
  } region_t;

  typedef struct packed {
    logic [ImageW-1:0] image;
    logic [ImageW-1:0] hotspot;
    logic [IndexW-1:0] index;
    logic [ImageW-1:0] prev;
  } hit_t;

  region_t           regions [MaxEntriesDef];
  logic [ImageW-1:0] shown_image;
  logic [CountW-1:0] used_count;
  hit_t              hits_pending [$];

  // lowest entry above the default that holds the point, else the default
  function automatic hit_t predict_hit(input logic [CW-1:0] x, input logic [CW-1:0] y);
    int unsigned n;
    int unsigned pick;
    hit_t        h;
    n = 32'(used_count);
    if (n == 0) n = 1;
    if (n > MaxEntriesDef) n = MaxEntriesDef;
    pick = 0;
    for (int unsigned k = 1; k < n; k++) begin
      if (pick == 0 && x >= regions[k].left && y >= regions[k].top &&
          regions[k].right >= x && regions[k].bottom >= y) begin
        pick = k;
      end
    end
    h.image   = regions[pick].image;
    h.hotspot = regions[pick].hotspot;
    h.index   = IndexW'(pick);
    h.prev    = shown_image;
    return h;
  endfunction

  function automatic int field_bad(input string name, input logic [ImageW-1:0] exp_v,
                                   input logic [ImageW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    hit_t want;
    int   errs;
    if (!rst_ni) begin
      shown_image <= '0;
      used_count  <= CountRst;
      hits_pending.delete();
      fail_cnt_o  <= 0;
      pending_o   <= 0;
    end else begin
      errs = 0;
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (hits_pending.size() == 0) begin
          $error("result item with no query outstanding");
          errs++;
        end else begin
          want = hits_pending.pop_front();
          errs += field_bad("image_number", want.image, rsp_mon.image_number);
          errs += field_bad("hotspot_offset", want.hotspot, rsp_mon.hotspot_offset);
          errs += field_bad("matched_index", ImageW'(want.index),
                            ImageW'(rsp_mon.matched_index));
          errs += field_bad("previous_image", want.prev, rsp_mon.previous_image);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) used_count <= cfg_mon.entry_count;
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.op == OpQuery) begin
          want = predict_hit(req_mon.cursor_x, req_mon.cursor_y);
          hits_pending.push_back(want);
          shown_image <= want.image;
        end else begin
          regions[req_mon.entry_index] <= '{req_mon.region_left, req_mon.region_top,
                                            req_mon.region_right, req_mon.region_bottom,
                                            req_mon.region_image, req_mon.region_hotspot};
        end
      end
      fail_cnt_o <= fail_cnt_o + errs;
      pending_o  <= hits_pending.size();
    end
  end
endmodule

[sim/tb_pointer_region_shape_lookup.sv]
// stimulus and verdict for the pointer region lookup
module tb_pointer_region_shape_lookup;
  timeunit 1ns;
  timeprecision 1ps;
  import prsl_pkg::*;

  localparam int unsigned CW         = CoordBitsDef;
  localparam int unsigned CoordMax   = (1 << CW) - 1;
  localparam int unsigned SettleWait = 40;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned PhaseItems = 95;

  typedef struct {
    logic              op;
    logic [IndexW-1:0] slot;
    logic [CW-1:0]     left;
    logic [CW-1:0]     top;
    logic [CW-1:0]     right;
    logic [CW-1:0]     bottom;
    logic [ImageW-1:0] image;
    logic [ImageW-1:0] hotspot;
    logic [CW-1:0]     px;
    logic [CW-1:0]     py;
  } pointer_op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          rsp_hold = 1'b0;

  // stimulus-side copy of the bounds, only used to aim queries at regions
  logic [CW-1:0] sh_left [MaxEntriesDef];
  logic [CW-1:0] sh_top [MaxEntriesDef];
  logic [CW-1:0] sh_right [MaxEntriesDef];
  logic [CW-1:0] sh_bottom [MaxEntriesDef];

  int unsigned phase_count [10] = '{16, 2, 31, 9, 0, 17, 16, 5, 1, 16};

  prsl_req_if req_if ();
  prsl_rsp_if rsp_if ();
  prsl_cfg_if cfg_if ();

  pointer_region_shape_lookup dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  pointer_hit_checker u_hit_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .cfg_mon    (cfg_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
  end

  function automatic pointer_op_t write_op(input int unsigned slot, input int unsigned l,
                                           input int unsigned t, input int unsigned r,
                                           input int unsigned b, input int unsigned img,
                                           input int unsigned hs);
    pointer_op_t it;
    it.op      = OpWrite;
    it.slot    = IndexW'(slot);
    it.left    = CW'(l);
    it.top     = CW'(t);
    it.right   = CW'(r);
    it.bottom  = CW'(b);
    it.image   = ImageW'(img);
    it.hotspot = ImageW'(hs);
    it.px      = CW'($urandom);
    it.py      = CW'($urandom);
    return it;
  endfunction

  function automatic pointer_op_t query_op(input int unsigned x, input int unsigned y);
    pointer_op_t it;
    it         = write_op($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
    it.op      = OpQuery;
    it.px      = CW'(x);
    it.py      = CW'(y);
    return it;
  endfunction

  function automatic int unsigned near_edge(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    case ($urandom_range(3))
      0:       return 32'(lo);
      1:       return 32'(hi);
      2:       return 32'(CW'(lo - 1));
      default: return 32'(CW'(hi + 1));
    endcase
  endfunction

  // mostly small regions and queries aimed at them, with some wide-open noise
  function automatic pointer_op_t rand_op();
    int unsigned r;
    int unsigned k;
    int unsigned l;
    int unsigned t;
    r = $urandom_range(99);
    if (r < 30) begin
      if (r < 4) return write_op($urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
      if (r < 7) begin
        l = $urandom_range(1, CoordMax);
        return write_op($urandom, l, $urandom, $urandom_range(l - 1), $urandom,
                        $urandom, $urandom);
      end
      l = $urandom_range(CoordMax);
      t = $urandom_range(CoordMax);
      return write_op($urandom, l, t, (l + $urandom_range(255) > CoordMax) ? CoordMax :
                      l + $urandom_range(255), (t + $urandom_range(255) > CoordMax) ?
                      CoordMax : t + $urandom_range(255), $urandom, $urandom);
    end
    k = $urandom_range(1, MaxEntriesDef - 1);
    if (r < 72 && sh_left[k] <= sh_right[k] && sh_top[k] <= sh_bottom[k]) begin
      return query_op($urandom_range(sh_left[k], sh_right[k]),
                      $urandom_range(sh_top[k], sh_bottom[k]));
    end
    if (r < 85) return query_op(near_edge(sh_left[k], sh_right[k]),
                                near_edge(sh_top[k], sh_bottom[k]));
    return query_op($urandom_range(CoordMax), $urandom_range(CoordMax));
  endfunction

  task automatic issue(input pointer_op_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.op             <= it.op;
    req_if.entry_index    <= it.slot;
    req_if.region_left    <= it.left;
    req_if.region_top     <= it.top;
    req_if.region_right   <= it.right;
    req_if.region_bottom  <= it.bottom;
    req_if.region_image   <= it.image;
    req_if.region_hotspot <= it.hotspot;
    req_if.cursor_x       <= it.px;
    req_if.cursor_y       <= it.py;
    req_if.valid          <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    if (it.op == OpWrite) begin
      sh_left[it.slot]   = it.left;
      sh_top[it.slot]    = it.top;
      sh_right[it.slot]  = it.right;
      sh_bottom[it.slot] = it.bottom;
    end
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // writes may still be in flight after the last result, so let the block settle
  task automatic set_count(input int unsigned n);
    wait_results();
    repeat (SettleWait) @(negedge clk_i);
    cfg_if.entry_count <= CountW'(n);
    cfg_if.valid       <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    req_if.valid          = 1'b0;
    req_if.op             = OpWrite;
    req_if.entry_index    = '0;
    req_if.region_left    = '0;
    req_if.region_top     = '0;
    req_if.region_right   = '0;
    req_if.region_bottom  = '0;
    req_if.region_image   = '0;
    req_if.region_hotspot = '0;
    req_if.cursor_x       = '0;
    req_if.cursor_y       = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.entry_count    = '0;
    rsp_if.ready          = 1'b0;
    for (int i = 0; i < MaxEntriesDef; i++) begin
      sh_left[i]   = '1;
      sh_top[i]    = '1;
      sh_right[i]  = '0;
      sh_bottom[i] = '0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // only the default entry is in use after reset
    issue(write_op(0, 0, 0, CoordMax, CoordMax, 255, 255));
    issue(query_op(0, 0));
    issue(query_op(CoordMax, CoordMax));
    set_count(0);
    issue(query_op(512, 512));

    // empty rectangles, single-point regions at the corners, overlap priority
    issue(write_op(1, 600, 0, 599, CoordMax, 1, 11));
    issue(write_op(2, 0, 700, CoordMax, 699, 2, 22));
    issue(write_op(3, CoordMax, CoordMax, CoordMax, CoordMax, 3, 0));
    issue(write_op(4, 0, 0, 0, 0, 4, 255));
    issue(write_op(5, 100, 100, 200, 200, 5, 55));
    issue(write_op(6, 150, 150, 250, 250, 6, 66));
    for (int i = 7; i < MaxEntriesDef; i++) begin
      issue(write_op(i, 300 + 60 * (i - 7), 300, 340 + 60 * (i - 7), 900, $urandom,
                     $urandom));
    end
    issue(write_op(0, 5, 5, 9, 9, 0, 0));
    set_count(31);
    issue(query_op(CoordMax, CoordMax));
    issue(query_op(0, 0));
    issue(query_op(150, 150));
    issue(query_op(200, 200));
    issue(query_op(201, 250));
    issue(query_op(251, 251));
    issue(query_op(100, 99));
    issue(query_op(600, 5));

    for (int ph = 0; ph < 10; ph++) begin
      set_count(phase_count[ph]);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 55; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 55; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      if (ph == 4) begin
        // long receiver hold-off while the sender keeps offering items
        fork
          begin
            @(posedge clk_i);
            rsp_hold = 1'b1;
            repeat (HoldCycles) @(posedge clk_i);
            rsp_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 6 && n == PhaseItems / 2) wait_results();
        issue(rand_op());
      end
    end

    wait_results();
    repeat (SettleWait) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
